// ===== sv/cstc_pkg.sv =====
// Shared types and constants for the command script tokenizer and checker.
package cstc_pkg;

    localparam int MAX_ARGS = 16;
    localparam int ARG_CAP_INT = ((MAX_ARGS - 1) > 15) ? 15 : (MAX_ARGS - 1);
    localparam logic [3:0] ARG_CAP = 4'(ARG_CAP_INT);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // token kinds
    localparam logic [2:0] K_IDENT  = 3'd0;
    localparam logic [2:0] K_NUMBER = 3'd1;
    localparam logic [2:0] K_STRING = 3'd2;
    localparam logic [2:0] K_COMMA  = 3'd3;
    localparam logic [2:0] K_LPAREN = 3'd4;
    localparam logic [2:0] K_RPAREN = 3'd5;
    localparam logic [2:0] K_END    = 3'd6;

    // token roles
    localparam logic [1:0] ROLE_NAME  = 2'd0;
    localparam logic [1:0] ROLE_ARG   = 2'd1;
    localparam logic [1:0] ROLE_OTHER = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NAME    = 3'd1;
    localparam logic [2:0] ERR_LPAREN  = 3'd2;
    localparam logic [2:0] ERR_BAD_ARG = 3'd3;
    localparam logic [2:0] ERR_RPAREN  = 3'd4;

    // event kinds
    localparam logic EV_BYTE = 1'b0;
    localparam logic EV_DONE = 1'b1;

    typedef enum logic [1:0] {
        LEX_IDLE   = 2'd0,
        LEX_IDENT  = 2'd1,
        LEX_NUMBER = 2'd2,
        LEX_STRING = 2'd3
    } lex_mode_t;

    typedef enum logic [1:0] {
        PH_NAME   = 2'd0,
        PH_LPAREN = 2'd1,
        PH_ARGS   = 2'd2
    } phase_t;

    // one lexer event passed from front to back
    typedef struct packed {
        logic       done;   // EV_BYTE or EV_DONE
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;   // final event of its input word
    } lex_event_t;

endpackage

// ===== sv/cstc_lexer.sv =====
// Front end: classifies each input character and produces up to two lexer events.
module cstc_lexer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_byte,
    input  logic                end_of_text,
    output logic                ev0_valid,
    output cstc_pkg::lex_event_t ev0,
    output logic                ev1_valid,
    output cstc_pkg::lex_event_t ev1
);
    import cstc_pkg::*;

    lex_mode_t mode_reg, mode_next;

    logic is_alpha, is_digit, is_space;
    logic is_quote, is_lp, is_rp, is_comma, is_under, is_dot, is_minus;
    logic cont;
    logic fresh_valid;
    lex_event_t fresh_ev;
    lex_mode_t fresh_mode;
    logic [2:0] mode_kind;

    assign is_alpha = (char_byte inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    assign is_digit = (char_byte inside {[8'h30:8'h39]});
    assign is_space = (char_byte == 8'h20) || (char_byte inside {[8'h09:8'h0D]});
    assign is_quote = (char_byte == 8'h22);
    assign is_lp    = (char_byte == 8'h28);
    assign is_rp    = (char_byte == 8'h29);
    assign is_comma = (char_byte == 8'h2C);
    assign is_under = (char_byte == 8'h5F);
    assign is_dot   = (char_byte == 8'h2E);
    assign is_minus = (char_byte == 8'h2D);

    assign cont = (mode_reg == LEX_IDENT) ? (is_alpha || is_digit || is_under || is_dot)
                                          : (is_digit || is_dot || is_minus);
    assign mode_kind = 3'(mode_reg) - 3'd1;

    // what a character does when it starts fresh
    always_comb
    begin
        fresh_valid = 1'b0;
        fresh_mode  = LEX_IDLE;
        fresh_ev    = '{done: EV_DONE, kind: K_COMMA, data: 8'h00, last: 1'b1};
        if (!is_space) begin
            if (is_alpha || is_under) begin
                fresh_mode  = LEX_IDENT;
                fresh_valid = 1'b1;
                fresh_ev    = '{done: EV_BYTE, kind: K_IDENT, data: char_byte, last: 1'b1};
            end else if (is_digit || is_minus) begin
                fresh_mode  = LEX_NUMBER;
                fresh_valid = 1'b1;
                fresh_ev    = '{done: EV_BYTE, kind: K_NUMBER, data: char_byte, last: 1'b1};
            end else if (is_quote) begin
                fresh_mode = LEX_STRING;
            end else if (is_lp) begin
                fresh_valid = 1'b1;
                fresh_ev.kind = K_LPAREN;
            end else if (is_rp) begin
                fresh_valid = 1'b1;
                fresh_ev.kind = K_RPAREN;
            end else if (is_comma) begin
                fresh_valid = 1'b1;
                fresh_ev.kind = K_COMMA;
            end
        end
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        if (end_of_text) begin
            mode_next = LEX_IDLE;
        end else begin
            case (mode_reg)
                LEX_STRING: mode_next = is_quote ? LEX_IDLE : LEX_STRING;
                LEX_IDENT, LEX_NUMBER: mode_next = cont ? mode_reg : fresh_mode;
                LEX_IDLE: mode_next = fresh_mode;
                default: mode_next = LEX_IDLE;
            endcase
        end
    end

    // event outputs
    always_comb
    begin
        ev0_valid = 1'b0;
        ev1_valid = 1'b0;
        ev0 = '{done: EV_DONE, kind: mode_kind, data: 8'h00, last: 1'b1};
        ev1 = '{done: EV_DONE, kind: K_END, data: 8'h00, last: 1'b1};
        if (end_of_text) begin
            ev0_valid = 1'b1;
            if (mode_reg != LEX_IDLE) begin
                ev1_valid = 1'b1;
                ev0.last  = 1'b0;
            end else begin
                ev0.kind = K_END;
            end
        end else begin
            case (mode_reg)
                LEX_STRING:
                begin
                    ev0_valid = 1'b1;
                    if (!is_quote) begin
                        ev0 = '{done: EV_BYTE, kind: K_STRING, data: char_byte, last: 1'b1};
                    end
                end
                LEX_IDENT, LEX_NUMBER:
                begin
                    ev0_valid = 1'b1;
                    if (cont) begin
                        ev0 = '{done: EV_BYTE, kind: mode_kind, data: char_byte, last: 1'b1};
                    end else if (fresh_valid) begin
                        ev0.last  = 1'b0;
                        ev1_valid = 1'b1;
                        ev1       = fresh_ev;
                    end
                end
                LEX_IDLE:
                begin
                    ev0_valid = fresh_valid;
                    ev0       = fresh_ev;
                end
                default:
                begin
                    ev0_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= LEX_IDLE;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ===== sv/cstc_queue.sv =====
// Small event queue between lexer and checker: two pushes, one pop per cycle.
module cstc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    output logic                 room,
    input  logic                 push0,
    input  cstc_pkg::lex_event_t din0,
    input  logic                 push1,
    input  cstc_pkg::lex_event_t din1,
    output logic                 head_valid,
    output cstc_pkg::lex_event_t head,
    input  logic                 pop
);
    import cstc_pkg::*;

    lex_event_t entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_1;
    logic [QCNT_W-1:0] n_push;

    // room for two events regardless of a pop this cycle
    assign room       = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign wr_ptr_1   = wr_ptr_reg + QPTR_W'(1);

    always_comb
    begin
        n_push = QCNT_W'(push0) + QCNT_W'(push1);
        wr_ptr_next = wr_ptr_reg + n_push[QPTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + n_push - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push0) begin
            entry_reg[wr_ptr_reg] <= din0;
        end
        if (push1) begin
            entry_reg[wr_ptr_1] <= din1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/cstc_checker.sv =====
// Back end: grammar checker that turns lexer events into result words.
module cstc_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ev_valid,
    input  cstc_pkg::lex_event_t ev,
    output logic                 ev_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 event_res,
    output logic [2:0]           token_kind,
    output logic [7:0]           value_byte,
    output logic [1:0]           token_role,
    output logic [3:0]           arg_index,
    output logic                 command_done,
    output logic [2:0]           error_code,
    output logic                 last
);
    import cstc_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       halted_reg, halted_next;
    logic       halt_now_reg, halt_now_next;   // halt came from the word in flight

    logic       out_valid_reg;
    logic       res_ev_reg, res_done_reg, res_last_reg;
    logic [2:0] res_kind_reg, res_err_reg;
    logic [7:0] res_val_reg;
    logic [1:0] res_role_reg;
    logic [3:0] res_idx_reg;

    logic       is_value_kind;
    logic [1:0] role;
    logic [3:0] idx;
    logic [2:0] err;
    logic       cmd_done;
    logic       drop;
    logic       emit;
    logic       r_ev, r_done, r_last;
    logic [2:0] r_kind, r_err;
    logic [7:0] r_val;
    logic [1:0] r_role;
    logic [3:0] r_idx;

    assign is_value_kind = (ev.kind <= K_STRING);

    // role, index and grammar verdict of the head event
    always_comb
    begin
        if (phase_reg == PH_ARGS && is_value_kind) begin
            role = ROLE_ARG;
        end else if (phase_reg == PH_NAME && ev.kind == K_IDENT) begin
            role = ROLE_NAME;
        end else begin
            role = ROLE_OTHER;
        end
        idx = (role == ROLE_ARG) ? cnt_reg : 4'd0;

        err = ERR_NONE;
        cmd_done = 1'b0;
        case (phase_reg)
            PH_LPAREN:
            begin
                if (ev.kind != K_LPAREN) begin
                    err = ERR_LPAREN;
                end
            end
            PH_ARGS:
            begin
                if (ev.kind == K_RPAREN) begin
                    cmd_done = 1'b1;
                end else if (ev.kind == K_END) begin
                    err = ERR_RPAREN;
                end else if (ev.kind == K_LPAREN) begin
                    err = ERR_BAD_ARG;
                end
            end
            default:
            begin
                if (ev.kind != K_IDENT && ev.kind != K_END) begin
                    err = ERR_NAME;
                end
            end
        endcase
    end

    assign emit   = ev_valid && !drop;
    assign ev_pop = ev_valid && (drop || !out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        halted_next   = halted_reg;
        halt_now_next = halt_now_reg;
        if (ev_pop) begin
            if (ev.done == EV_DONE && ev.kind == K_END) begin
                phase_next    = PH_NAME;
                cnt_next      = 4'd0;
                halted_next   = 1'b0;
                halt_now_next = 1'b0;
            end else if (halted_reg) begin
                if (ev.last) begin
                    halt_now_next = 1'b0;
                end
            end else if (ev.done == EV_DONE) begin
                if (err != ERR_NONE) begin
                    halted_next   = 1'b1;
                    halt_now_next = !ev.last;
                end else begin
                    case (phase_reg)
                        PH_LPAREN:
                        begin
                            phase_next = PH_ARGS;
                            cnt_next   = 4'd0;
                        end
                        PH_ARGS:
                        begin
                            if (is_value_kind && cnt_reg < ARG_CAP) begin
                                cnt_next = cnt_reg + 4'd1;
                            end else if (ev.kind == K_RPAREN) begin
                                phase_next = PH_NAME;
                            end
                        end
                        default:
                        begin
                            if (ev.kind == K_IDENT) begin
                                phase_next = PH_LPAREN;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // result word
    always_comb
    begin
        drop   = 1'b0;
        r_ev   = ev.done;
        r_kind = ev.kind;
        r_val  = 8'h00;
        r_role = role;
        r_idx  = idx;
        r_done = 1'b0;
        r_err  = ERR_NONE;
        r_last = ev.last;
        if (halted_reg) begin
            // only end-of-text speaks while halted, unless it belongs to the failing word
            drop   = !(ev.done == EV_DONE && ev.kind == K_END) || halt_now_reg;
            r_role = ROLE_OTHER;
            r_idx  = 4'd0;
            r_last = 1'b1;
        end else if (ev.done == EV_BYTE) begin
            r_val = ev.data;
        end else begin
            r_done = cmd_done;
            r_err  = err;
            r_last = ev.last || (err != ERR_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_pop && emit) begin
            res_ev_reg   <= r_ev;
            res_kind_reg <= r_kind;
            res_val_reg  <= r_val;
            res_role_reg <= r_role;
            res_idx_reg  <= r_idx;
            res_done_reg <= r_done;
            res_err_reg  <= r_err;
            res_last_reg <= r_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_NAME;
            cnt_reg       <= 4'd0;
            halted_reg    <= 1'b0;
            halt_now_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            halted_reg   <= halted_next;
            halt_now_reg <= halt_now_next;
            if (ev_pop && emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = res_ev_reg;
    assign token_kind   = res_kind_reg;
    assign value_byte   = res_val_reg;
    assign token_role   = res_role_reg;
    assign arg_index    = res_idx_reg;
    assign command_done = res_done_reg;
    assign error_code   = res_err_reg;
    assign last         = res_last_reg;

endmodule

// ===== sv/command_script_tokenizer_checker.sv =====
// Top level of the command script tokenizer and grammar checker.
// Path: the accepting edge writes the lexer events of an input word into the queue;
// the checker then turns the head event into a result word in the output register
// when the output side is free.
// Throughput: one input word per cycle while the queue has room; the checker
// delivers one result word per cycle when the output is not stalled, so a run of
// words that cause two results slows input once the queue fills.
// Reset: rst_n (async, active low) clears lexer mode, parse phase, argument count,
// halt flags, queue pointers and count, and output valid; payload registers are not reset.
module command_script_tokenizer_checker (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       end_of_text,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic       event_res,
    output logic [2:0] token_kind,
    output logic [7:0] value_byte,
    output logic [1:0] token_role,
    output logic [3:0] arg_index,
    output logic       command_done,
    output logic [2:0] error_code,
    output logic       last
);
    import cstc_pkg::*;

    logic       accept;
    logic       ev0_valid, ev1_valid;
    lex_event_t ev0, ev1;
    logic       q_room;
    logic       head_valid;
    lex_event_t head;
    logic       pop;

    // The queue must hold both events a word may produce before we take it.
    assign in_ready = q_room;
    assign accept   = in_valid && in_ready;

    // Front: the lexer tracks the open token and emits value-byte and
    // token-done events; it never looks at the grammar state.
    cstc_lexer u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_byte   (char_byte),
        .end_of_text (end_of_text),
        .ev0_valid   (ev0_valid),
        .ev0         (ev0),
        .ev1_valid   (ev1_valid),
        .ev1         (ev1)
    );

    // Queue decouples lexing from checking so either side may stall.
    cstc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .room       (q_room),
        .push0      (accept && ev0_valid),
        .din0       (ev0),
        .push1      (accept && ev1_valid),
        .din1       (ev1),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Back: the checker applies the grammar, owns the halt flag and drops
    // events after an error until the end-of-text event; that event also
    // clears the grammar state. The lexer clears its own mode on end of
    // text, so the two halves stay in step without feedback.
    cstc_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .ev_valid     (head_valid),
        .ev           (head),
        .ev_pop       (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .token_kind   (token_kind),
        .value_byte   (value_byte),
        .token_role   (token_role),
        .arg_index    (arg_index),
        .command_done (command_done),
        .error_code   (error_code),
        .last         (last)
    );

endmodule
